FILE: hdl/text_byte_stream_decoder_defines.svh
// Assertion macros used by the back end of the text byte stream decoder.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef TEXT_BYTE_STREAM_DECODER_DEFINES_SVH
`define TEXT_BYTE_STREAM_DECODER_DEFINES_SVH

// Plain property, checked on every rising edge outside reset.
`define TBSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tbsd assertion failed");

// Implication with the consequent checked in the next cycle.
`define TBSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbsd assertion failed");

`endif

FILE: hdl/tbsd_pkg.sv
// Shared types, constants and the Windows-1252 table of the text byte stream decoder.
// No dependencies.
package tbsd_pkg;

  localparam int unsigned CfgAddrWidth = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_ENDIAN = 2'd1;
  localparam logic [1:0] REG_BOM    = 2'd2;

  // Encoding mode codes.
  localparam logic [2:0] MODE_ASCII  = 3'd0;
  localparam logic [2:0] MODE_CP1252 = 3'd1;
  localparam logic [2:0] MODE_UTF8   = 3'd2;
  localparam logic [2:0] MODE_UTF16  = 3'd3;
  localparam logic [2:0] MODE_UTF32  = 3'd4;
  localparam logic [2:0] MODE_RESET  = MODE_UTF8;

  // Byte order mark lengths.
  localparam logic [2:0] BOM_LEN_UTF8  = 3'd3;
  localparam logic [2:0] BOM_LEN_UTF16 = 3'd2;
  localparam logic [2:0] BOM_LEN_UTF32 = 3'd4;

  localparam logic [7:0]  CHAR_QUESTION  = 8'h3F;
  localparam logic [2:0]  CP1252_HI_TAG  = 3'b100;
  localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [31:0] SUPP_BASE      = 32'h0001_0000;

  typedef struct packed {
    logic [2:0] mode;
    logic       big_endian;
    logic       bom_present;
  } cfg_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       skip;
  } item_t;

  // Windows-1252 code points for bytes 0x80 to 0x9F; zero marks undefined bytes.
  function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:  v = 16'h20AC;
      5'd1:  v = 16'h0000;
      5'd2:  v = 16'h201A;
      5'd3:  v = 16'h0192;
      5'd4:  v = 16'h201E;
      5'd5:  v = 16'h2026;
      5'd6:  v = 16'h2020;
      5'd7:  v = 16'h2021;
      5'd8:  v = 16'h02C6;
      5'd9:  v = 16'h2030;
      5'd10: v = 16'h0160;
      5'd11: v = 16'h2039;
      5'd12: v = 16'h0152;
      5'd13: v = 16'h0000;
      5'd14: v = 16'h017D;
      5'd15: v = 16'h0000;
      5'd16: v = 16'h0000;
      5'd17: v = 16'h2018;
      5'd18: v = 16'h2019;
      5'd19: v = 16'h201C;
      5'd20: v = 16'h201D;
      5'd21: v = 16'h2022;
      5'd22: v = 16'h2013;
      5'd23: v = 16'h2014;
      5'd24: v = 16'h02DC;
      5'd25: v = 16'h2122;
      5'd26: v = 16'h0161;
      5'd27: v = 16'h203A;
      5'd28: v = 16'h0153;
      5'd29: v = 16'h0000;
      5'd30: v = 16'h017E;
      5'd31: v = 16'h0178;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/tbsd_front.sv
// Front end: accepts bytes, skips the byte order mark and classifies each item.
// Depends on tbsd_pkg.
module tbsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbsd_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 file_start_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output tbsd_pkg::item_t      item_o
);
  import tbsd_pkg::*;

  logic [2:0] bom_left_q, bom_left_d;
  logic [2:0] bom_load;
  logic [2:0] bom_now;
  logic       skip;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    bom_load = 3'd0;
    if (cfg_i.bom_present) begin
      unique case (cfg_i.mode)
        MODE_UTF8:  bom_load = BOM_LEN_UTF8;
        MODE_UTF16: bom_load = BOM_LEN_UTF16;
        MODE_UTF32: bom_load = BOM_LEN_UTF32;
        default:    bom_load = 3'd0;
      endcase
    end
    bom_now = file_start_i ? bom_load : bom_left_q;
    if (bom_now != 3'd0) begin
      skip       = 1'b1;
      bom_left_d = bom_now - 3'd1;
    end else begin
      // Reserved mode codes drop the byte without a result.
      skip       = (cfg_i.mode > MODE_UTF32);
      bom_left_d = 3'd0;
    end
  end

  assign item_o = '{data: data_byte_i, restart: file_start_i, skip: skip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bom_left_q <= 3'd0;
    end else if (push_o) begin
      bom_left_q <= bom_left_d;
    end
  end

endmodule

FILE: hdl/tbsd_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Depends on tbsd_pkg.
module tbsd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tbsd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tbsd_pkg::item_t item_o
);
  import tbsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/tbsd_back.sv
// Back end: decodes classified bytes into code points and holds the result register.
// Depends on tbsd_pkg and text_byte_stream_decoder_defines.svh.
`include "text_byte_stream_decoder_defines.svh"

module tbsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbsd_pkg::cfg_t  cfg_i,
  input  logic            cfg_clear_i,
  input  logic            item_valid_i,
  input  tbsd_pkg::item_t item_i,
  output logic            item_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     code_point_o,
  output logic [15:0]     utf16_first_o,
  output logic [15:0]     utf16_second_o,
  output logic            utf16_pair_o,
  output logic            decode_error_o
);
  import tbsd_pkg::*;

  logic [2:0]  pend_q, pend_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] part_q, part_d;
  logic [9:0]  hs_q, hs_d;
  logic        sw_q, sw_d;
  logic        emit;
  logic        err;
  logic [31:0] cp;
  logic        take;
  logic        out_valid_q;
  logic [31:0] cp_q;
  logic        err_q;
  logic [31:0] supp_off;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] hv;
    logic [15:0] unit;
    logic [1:0]  last_pos;
    b      = item_i.data;
    pend_d = pend_q;
    pos_d  = pos_q;
    part_d = part_q;
    hs_d   = hs_q;
    sw_d   = sw_q;
    if (item_i.restart) begin
      pend_d = 3'd0;
      pos_d  = 2'd0;
      part_d = 32'd0;
      hs_d   = 10'd0;
      sw_d   = 1'b0;
    end
    emit     = 1'b0;
    err      = 1'b0;
    cp       = 32'd0;
    hv       = 16'd0;
    unit     = 16'd0;
    last_pos = 2'd0;
    if (!item_i.skip) begin
      unique case (cfg_i.mode)
        MODE_ASCII: begin
          emit = 1'b1;
          cp   = {24'd0, b};
        end
        MODE_CP1252: begin
          emit = 1'b1;
          if (b[7:5] == CP1252_HI_TAG) begin
            hv = cp1252_high(b[4:0]);
            cp = (hv == 16'd0) ? {24'd0, CHAR_QUESTION} : {16'd0, hv};
          end else begin
            cp = {24'd0, b};
          end
        end
        MODE_UTF8: begin
          if (pend_d != 3'd0) begin
            part_d = {part_d[25:0], b[5:0]};
            pend_d = pend_d - 3'd1;
            if (pend_d == 3'd0) begin
              emit = 1'b1;
              cp   = part_d;
            end
          end else if (!b[7]) begin
            emit = 1'b1;
            cp   = {24'd0, b};
          end else if (!b[6]) begin
            // A stray continuation byte stands for its own low six bits.
            part_d = {26'd0, b[5:0]};
            emit   = 1'b1;
            cp     = part_d;
          end else if (!b[5]) begin
            part_d = {27'd0, b[4:0]};
            pend_d = 3'd1;
          end else if (!b[4]) begin
            part_d = {28'd0, b[3:0]};
            pend_d = 3'd2;
          end else if (!b[3]) begin
            part_d = {29'd0, b[2:0]};
            pend_d = 3'd3;
          end else begin
            emit = 1'b1;
            err  = 1'b1;
          end
        end
        MODE_UTF16, MODE_UTF32: begin
          last_pos = (cfg_i.mode == MODE_UTF16) ? 2'd1 : 2'd3;
          if (pos_d == 2'd0) begin
            part_d = 32'd0;
          end
          if (cfg_i.big_endian) begin
            part_d = {part_d[23:0], b};
          end else begin
            part_d = part_d | ({24'd0, b} << {pos_d, 3'b000});
          end
          if (pos_d < last_pos) begin
            pos_d = pos_d + 2'd1;
          end else begin
            pos_d = 2'd0;
            if (cfg_i.mode == MODE_UTF32) begin
              emit = 1'b1;
              cp   = part_d;
            end else begin
              unit = part_d[15:0];
              if (sw_d) begin
                // Whatever follows a high surrogate lends its low ten bits.
                cp   = {12'd0, hs_d, unit[9:0]} + SUPP_BASE;
                emit = 1'b1;
                sw_d = 1'b0;
                hs_d = 10'd0;
              end else if (unit[15:10] == HIGH_SURR_TAG) begin
                hs_d = unit[9:0];
                sw_d = 1'b1;
              end else begin
                emit = 1'b1;
                cp   = {16'd0, unit};
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 3'd0;
      pos_q       <= 2'd0;
      part_q      <= 32'd0;
      hs_q        <= 10'd0;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_clear_i) begin
        pend_q <= 3'd0;
        pos_q  <= 2'd0;
        part_q <= 32'd0;
        hs_q   <= 10'd0;
        sw_q   <= 1'b0;
      end else if (take) begin
        pend_q <= pend_d;
        pos_q  <= pos_d;
        part_q <= part_d;
        hs_q   <= hs_d;
        sw_q   <= sw_d;
      end
      if (take) begin
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      cp_q  <= cp;
      err_q <= err;
    end
  end

  // UTF-16 form of the held code point.
  assign supp_off       = cp_q - SUPP_BASE;
  assign utf16_pair_o   = (cp_q[31:16] != 16'd0);
  assign utf16_first_o  = utf16_pair_o ? (SURR_HIGH_BASE | supp_off[25:10]) : cp_q[15:0];
  assign utf16_second_o = utf16_pair_o ? (SURR_LOW_BASE | {6'd0, supp_off[9:0]}) : 16'd0;
  assign code_point_o   = cp_q;
  assign decode_error_o = err_q;
  assign out_valid_o    = out_valid_q;

  `TBSD_ASSERT(a_modes_exclusive, !(sw_q && (pend_q != 3'd0)))
  `TBSD_ASSERT(a_utf16_position, (cfg_i.mode != MODE_UTF16) || (pos_q <= 2'd1))
  `TBSD_ASSERT(a_error_zero_cp, !(out_valid_q && err_q) || (cp_q == 32'd0))
  `TBSD_ASSERT_NEXT(a_cfg_clears, cfg_clear_i, (pend_q == 3'd0) && (pos_q == 2'd0) && !sw_q)

endmodule

FILE: hdl/text_byte_stream_decoder.sv
// Top level of the text byte stream decoder: configuration registers and the
// front, queue and back parts. Depends on tbsd_pkg, tbsd_front, tbsd_queue, tbsd_back.
//
// The decoder takes a file one byte per item and turns ASCII, Windows-1252,
// UTF-8, UTF-16 or UTF-32 (either byte order) into Unicode code points. Each
// completed character gives one result item carrying the code point, its UTF-16
// form (a single unit or a surrogate pair, with utf16_pair set for the pair)
// and decode_error, which flags a UTF-8 lead byte with five or more leading
// ones. Bytes that only build up a character, and byte order mark bytes, give
// no result. Raise file_start on the first byte of each file: it restarts the
// decoder and, when bom_present is set, skips three bytes in UTF-8, two in
// UTF-16 and four in UTF-32. Overlong UTF-8 forms and lone low surrogates are
// passed through unchanged; undefined Windows-1252 bytes give '?'. The block
// sustains one byte per clock while results are taken: every byte needs a
// single decode step in the back end, and the front end feeds it through a
// short queue so that a stalled output does not immediately stop input. A
// result passes through the queue and then the result register before it is
// offered. Registers sit at byte addresses 0 (encoding_mode),
// 4 (big_endian_source) and 8 (bom_present); write them only while the block
// is idle. A write to one of them restarts the decoding state but keeps a byte
// order mark skip in progress. Reserved encoding codes 5 to 7 drop every byte.
module text_byte_stream_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tbsd_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Byte input channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               file_start_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        code_point_o,
  output logic [15:0]                        utf16_first_o,
  output logic [15:0]                        utf16_second_o,
  output logic                               utf16_pair_o,
  output logic                               decode_error_o
);
  import tbsd_pkg::*;

  logic [2:0] mode_q;
  logic       endian_q;
  logic       bom_q;
  logic       cfg_write;
  logic       cfg_clear;
  logic [1:0] reg_idx;
  cfg_t       cfg;

  item_t      front_item;
  item_t      queue_item;
  logic       push;
  logic       queue_full;
  logic       queue_valid;
  logic       back_ready;

  // The port never waits; a write lands on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];
  // Only writes to a defined register restart the decoding state.
  assign cfg_clear = cfg_write &&
                     ((reg_idx == REG_MODE) || (reg_idx == REG_ENDIAN) || (reg_idx == REG_BOM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      endian_q <= 1'b0;
      bom_q    <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MODE:   mode_q   <= pwdata[2:0];
        REG_ENDIAN: endian_q <= pwdata[0];
        REG_BOM:    bom_q    <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = {29'd0, mode_q};
      REG_ENDIAN: prdata = {31'd0, endian_q};
      REG_BOM:    prdata = {31'd0, bom_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg = '{mode: mode_q, big_endian: endian_q, bom_present: bom_q};

  // Front end: byte order mark skipping and classification.
  tbsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Queue that decouples the two sides.
  tbsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (back_ready),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // Back end: decoding state, UTF-16 forming and the result register.
  tbsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cfg_clear_i    (cfg_clear),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .item_ready_o   (back_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .utf16_first_o  (utf16_first_o),
    .utf16_second_o (utf16_second_o),
    .utf16_pair_o   (utf16_pair_o),
    .decode_error_o (decode_error_o)
  );

endmodule
